// ===== rtl/dsp_pkg.sv =====
// Shared types, constants and helpers of the dark-speck removal block.
package dsp_pkg;

	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WIDTH  = 4096;

	// Effective geometry limits and the storage that follows from them.
	localparam int H_LIM  = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
	localparam int W_LIM  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam int ADDR_W = $clog2(H_LIM);

	localparam int ROW_W      = 10;
	localparam int COL_W      = 12;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int WIDTH_W    = 13;
	localparam int HEIGHT_W   = 11;
	localparam int PEND_W     = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	// Window geometry: five columns by five rows around the center pixel.
	localparam int WIN         = 5;
	localparam int CENTER      = 2;
	localparam int MARGIN      = 2;
	localparam int SPECK_LIMIT = 5;
	localparam int SLOT_W      = 3;
	localparam int SUM_W       = 5;

	typedef logic [PIX_W-1:0] pixel_t;

	localparam pixel_t WHITE = {PIX_W{1'b1}};

	localparam logic [CH_W-1:0]     THRESHOLD_RESET = 8'd127;
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 13'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 11'd480;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic shift;
		logic set_white;
		logic white_dark;
	} cell_ctrl_t;

	// One window row: dark flags of the five columns and the center-column pixel.
	typedef struct packed {
		logic [WIN-1:0] dark;
		pixel_t         pix;
	} cell_data_t;

	function automatic logic is_dark(input pixel_t p, input logic [CH_W-1:0] thr);
		return (p[3*CH_W-1:2*CH_W] <= thr) && (p[2*CH_W-1:CH_W] <= thr) &&
			(p[CH_W-1:0] <= thr);
	endfunction

endpackage

// ===== rtl/despeckle_dark_pixel_5x5_unit.sv =====
// Top level of the dark-speck removal block: control, column buffers and window chain.
// A transaction that causes no result leaves the input free. One that finishes a pixel
// stalls the input while the controller steps through S_LOAD and S_SHIFT for each window
// row and then S_DECIDE, which loads the result register and frees the input; an output
// stall holds it in S_DECIDE. One window row is read from the column buffers and shifted
// into the chain per pixel, three at a column start.
// Reset clears all counters and the output valid and loads the register defaults;
// the column buffers are not cleared and hold garbage until written by the stream.
module despeckle_dark_pixel_5x5_unit import dsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [CH_W-1:0]       red_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       blue_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_W-1:0]       red_out,
	output logic [CH_W-1:0]       green_out,
	output logic [CH_W-1:0]       blue_out,
	output logic [COL_W-1:0]      out_column,
	output logic [ROW_W-1:0]      out_row,
	output logic                  was_removed,
	output logic                  frame_end
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOAD   = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
		input logic [SLOT_W:0] k);
		logic [SLOT_W:0] s;
		s = {1'b0, slot} + k;
		if (s >= (SLOT_W+1)'(WIN)) s = s - (SLOT_W+1)'(WIN);
		if (s >= (SLOT_W+1)'(WIN)) s = s - (SLOT_W+1)'(WIN);
		return s[SLOT_W-1:0];
	endfunction

	state_t state_q;

	logic [CH_W-1:0]     thr_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  em_row_q;
	logic [COL_W-1:0]  em_col_q;
	logic [PEND_W-1:0] pend_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [SLOT_W-1:0] em_slot_q;
	logic [ROW_W-1:0]  load_row_q;
	logic [1:0]        loads_left_q;

	logic              out_valid_q;
	pixel_t            out_pix_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_removed_q;
	logic              out_end_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [COL_W-1:0]    lag;

	logic                in_acc;
	logic                px_acc;
	logic [HEIGHT_W-1:0] in_row_inc;
	logic [WIDTH_W-1:0]  in_col_inc;
	logic [PEND_W-1:0]   pend_inc;
	logic                start_emit;

	logic                go;
	logic                interior;
	logic                removed;
	logic                white_dark;
	logic [HEIGHT_W-1:0] em_row_inc;
	logic [WIDTH_W-1:0]  em_col_inc;

	logic [WIN-1:0]    mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	pixel_t            mem_wdata;
	pixel_t            rd_data [WIN];
	logic [WIN-1:0]    rd_dark;

	cell_data_t       new_row;
	cell_data_t       chain_q [WIN];
	cell_ctrl_t       cell_ctrl [WIN];
	logic [SUM_W-1:0] sum_c [WIN+1];

	// Effective geometry, clamped to the supported range.
	always_comb begin
		if (width_q == '0) w_eff = WIDTH_W'(1);
		else if (width_q > WIDTH_W'(W_LIM)) w_eff = WIDTH_W'(W_LIM);
		else w_eff = width_q;
		if (height_q == '0) h_eff = HEIGHT_W'(1);
		else if (height_q > HEIGHT_W'(H_LIM)) h_eff = HEIGHT_W'(H_LIM);
		else h_eff = height_q;
		lag = COL_W'({h_eff, 1'b0}) + COL_W'(2);
	end

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign px_acc     = in_acc && (command == CMD_PIXEL);
	assign in_row_inc = {1'b0, in_row_q} + HEIGHT_W'(1);
	assign in_col_inc = {1'b0, in_col_q} + WIDTH_W'(1);
	assign pend_inc   = (pend_q != {PEND_W{1'b1}}) ? pend_q + PEND_W'(1) : pend_q;

	// A drain only counts at the start of a frame while pixels are still pending.
	always_comb begin
		if (command == CMD_DRAIN) begin
			start_emit = in_acc && (pend_q != '0) && (in_col_q == '0) && (in_row_q == '0);
		end else begin
			start_emit = in_acc && (pend_inc > PEND_W'(lag));
		end
	end

	assign go         = (state_q == S_DECIDE) && (!out_valid_q || !out_stall);
	assign white_dark = is_dark(WHITE, thr_q);
	assign interior   = (em_col_q >= COL_W'(MARGIN)) &&
		(WIDTH_W'(em_col_q) + WIDTH_W'(MARGIN) < w_eff) &&
		(em_row_q >= ROW_W'(MARGIN)) &&
		(HEIGHT_W'(em_row_q) + HEIGHT_W'(MARGIN) < h_eff);
	assign removed    = interior && chain_q[CENTER].dark[CENTER] &&
		(sum_c[WIN] < SUM_W'(SPECK_LIMIT));
	assign em_row_inc = {1'b0, em_row_q} + HEIGHT_W'(1);
	assign em_col_inc = {1'b0, em_col_q} + WIDTH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[CH_W-1:0];
				REG_WIDTH:     width_q <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT:    height_q <= cfg_data[HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_row_q     <= '0;
			in_col_q     <= '0;
			em_row_q     <= '0;
			em_col_q     <= '0;
			pend_q       <= '0;
			wr_slot_q    <= '0;
			em_slot_q    <= '0;
			load_row_q   <= '0;
			loads_left_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (px_acc) begin
						pend_q <= pend_inc;
						if (in_row_inc >= h_eff) begin
							in_row_q  <= '0;
							wr_slot_q <= slot_add(wr_slot_q, (SLOT_W+1)'(1));
							in_col_q  <= (in_col_inc >= w_eff) ? '0 : in_col_inc[COL_W-1:0];
						end else begin
							in_row_q <= in_row_inc[ROW_W-1:0];
						end
					end
					if (start_emit) begin
						state_q <= S_LOAD;
						// The first pixel of a column needs rows 0 to 2 loaded first.
						if (em_row_q == '0) begin
							load_row_q   <= '0;
							loads_left_q <= 2'd2;
						end else begin
							load_row_q   <= em_row_q + ROW_W'(MARGIN);
							loads_left_q <= 2'd0;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (loads_left_q != 2'd0) begin
						loads_left_q <= loads_left_q - 2'd1;
						load_row_q   <= load_row_q + ROW_W'(1);
						state_q      <= S_LOAD;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (go) begin
						state_q <= S_IDLE;
						if (pend_q != '0) pend_q <= pend_q - PEND_W'(1);
						if (em_row_inc >= h_eff) begin
							em_row_q  <= '0;
							em_slot_q <= slot_add(em_slot_q, (SLOT_W+1)'(1));
							em_col_q  <= (em_col_inc >= w_eff) ? '0 : em_col_inc[COL_W-1:0];
						end else begin
							em_row_q <= em_row_inc[ROW_W-1:0];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_pix_q     <= removed ? WHITE : chain_q[CENTER].pix;
			out_col_q     <= em_col_q;
			out_row_q     <= em_row_q;
			out_removed_q <= removed;
			out_end_q     <= (em_col_inc >= w_eff) && (em_row_inc >= h_eff);
		end
	end

	assign out_valid   = out_valid_q;
	assign red_out     = out_pix_q[3*CH_W-1:2*CH_W];
	assign green_out   = out_pix_q[2*CH_W-1:CH_W];
	assign blue_out    = out_pix_q[CH_W-1:0];
	assign out_column  = out_col_q;
	assign out_row     = out_row_q;
	assign was_removed = out_removed_q;
	assign frame_end   = out_end_q;

	// Incoming pixels and write-backs of removed pixels share each buffer's write port.
	assign mem_waddr = (state_q == S_DECIDE) ? em_row_q[ADDR_W-1:0] : in_row_q[ADDR_W-1:0];
	assign mem_wdata = (state_q == S_DECIDE) ? WHITE : {red_in, green_in, blue_in};

	for (genvar m = 0; m < WIN; m++) begin : g_buf
		assign mem_we[m] = (px_acc && (wr_slot_q == SLOT_W'(m))) ||
			(go && removed && (em_slot_q == SLOT_W'(m)));

		dsp_colbuf u_buf (
			.clk   (clk),
			.we    (mem_we[m]),
			.waddr (mem_waddr),
			.wdata (mem_wdata),
			.raddr (load_row_q[ADDR_W-1:0]),
			.rdata (rd_data[m])
		);

		assign rd_dark[m] = is_dark(rd_data[m], thr_q);
	end

	// Window column dc sits dc - 2 columns from the emitted one, in buffer order.
	always_comb begin
		for (int dc = 0; dc < WIN; dc++) begin
			new_row.dark[dc] = rd_dark[slot_add(em_slot_q, (SLOT_W+1)'(WIN - CENTER + dc))];
		end
		new_row.pix = rd_data[em_slot_q];
	end

	assign sum_c[0] = '0;

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		assign cell_ctrl[i].shift      = (state_q == S_SHIFT);
		assign cell_ctrl[i].set_white  = (i == CENTER) && go && removed;
		assign cell_ctrl[i].white_dark = white_dark;

		if (i == WIN - 1) begin : g_bottom
			dsp_cell u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl[i]),
				.nbr     (new_row),
				.sum_in  (sum_c[i]),
				.q       (chain_q[i]),
				.sum_out (sum_c[i+1])
			);
		end else begin : g_inner
			dsp_cell u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl[i]),
				.nbr     (chain_q[i+1]),
				.sum_in  (sum_c[i]),
				.q       (chain_q[i]),
				.sum_out (sum_c[i+1])
			);
		end
	end

	a_load_then_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |=> (state_q == S_SHIFT))
		else $error("buffer read not followed by a chain shift");

	a_result_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (out_valid_q && (out_row == $past(em_row_q))))
		else $error("decided pixel did not reach the output register");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we != '0) |-> ((state_q == S_IDLE) || (state_q == S_DECIDE)))
		else $error("column buffer written outside accept or write-back");

	a_center_patched: assert property (@(posedge clk) disable iff (!arst_n)
		(go && removed) |=> (chain_q[CENTER].pix == WHITE))
		else $error("removed pixel not patched in the window");

endmodule

// ===== rtl/dsp_colbuf.sv =====
// One column buffer: a pixel memory with one write port and a registered read port.
module dsp_colbuf import dsp_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  pixel_t            wdata,
	input  logic [ADDR_W-1:0] raddr,
	output pixel_t            rdata
);

	pixel_t mem [H_LIM];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dsp_cell.sv =====
// One row cell of the window chain: holds a window row and adds its dark count.
module dsp_cell import dsp_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  cell_data_t       nbr,
	input  logic [SUM_W-1:0] sum_in,
	output cell_data_t       q,
	output logic [SUM_W-1:0] sum_out
);

	logic [SUM_W-1:0] ones;

	// Rows move up one cell per shift; a removed center pixel is patched in place.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			q <= nbr;
		end else if (ctrl.set_white) begin
			q.pix         <= WHITE;
			q.dark[CENTER] <= ctrl.white_dark;
		end
	end

	always_comb begin
		ones = '0;
		for (int i = 0; i < WIN; i++) begin
			ones = ones + SUM_W'(q.dark[i]);
		end
		sum_out = sum_in + ones;
	end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the 5x5 dark-speck removal unit with its own pixel predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dsp_pkg::*;

	localparam int PERIOD       = 20;
	localparam int RESET_CYCLES = 7;
	localparam int IDLE_PCT     = 13;
	localparam int SETTLE       = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PIXEL_TARGET = 740;
	localparam int SHOWN_ERRORS = 10;

	typedef struct {
		logic   cmd;
		pixel_t pix;
	} stream_item_t;

	typedef struct {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             removed;
		logic             last;
	} finished_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  command = CMD_PIXEL;
	logic [CH_W-1:0]       red_in = '0;
	logic [CH_W-1:0]       green_in = '0;
	logic [CH_W-1:0]       blue_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CH_W-1:0]       red_out;
	logic [CH_W-1:0]       green_out;
	logic [CH_W-1:0]       blue_out;
	logic [COL_W-1:0]      out_column;
	logic [ROW_W-1:0]      out_row;
	logic                  was_removed;
	logic                  frame_end;

	despeckle_dark_pixel_5x5_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.out_column  (out_column),
		.out_row     (out_row),
		.was_removed (was_removed),
		.frame_end   (frame_end)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Predictor state: five column buffers, geometry and stream counters.
	pixel_t              col_mem [WIN * MAX_HEIGHT];
	logic [CH_W-1:0]     thr_q = THRESHOLD_RESET;
	logic [WIDTH_W-1:0]  width_q = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_q = HEIGHT_RESET;
	int unsigned         wr_col = 0, wr_row = 0, wr_slot = 0;
	int unsigned         rd_col = 0, rd_row = 0, rd_slot = 0;
	int unsigned         backlog = 0;

	stream_item_t    stream_items [$];
	finished_pixel_t due_pixels [$];
	stream_item_t    shown_item;

	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int errors = 0;
	int pixels_sent = 0, drains_sent = 0, pixels_queued = 0;
	int results_seen = 0, removed_seen = 0, phases = 0;
	int quiet_cycles = 0;

	function automatic int unsigned eff_cols();
		if (width_q == 0)
			return 1;
		return (width_q > W_LIM) ? W_LIM : width_q;
	endfunction

	function automatic int unsigned eff_rows();
		if (height_q == 0)
			return 1;
		return (height_q > H_LIM) ? H_LIM : height_q;
	endfunction

	function automatic logic dark_px(pixel_t p);
		return (p[3*CH_W-1:2*CH_W] <= thr_q) && (p[2*CH_W-1:CH_W] <= thr_q) &&
			(p[CH_W-1:0] <= thr_q);
	endfunction

	function automatic int unsigned mem_addr(int unsigned slot, int unsigned row);
		return (slot % WIN) * MAX_HEIGHT + (row % MAX_HEIGHT);
	endfunction

	function automatic stream_item_t make_item(logic cmd, pixel_t p);
		stream_item_t it;
		it.cmd = cmd;
		it.pix = p;
		return it;
	endfunction

	// Decides the oldest pending pixel; a removed speck is written back to the buffer.
	task automatic decide_pixel();
		int unsigned     w, h, c, r, addr, n, s;
		pixel_t          p;
		finished_pixel_t res;
		w = eff_cols();
		h = eff_rows();
		c = rd_col;
		r = rd_row;
		addr = mem_addr(rd_slot, r);
		p = col_mem[addr];
		res.removed = 1'b0;
		if (c >= MARGIN && c + MARGIN < w && r >= MARGIN && r + MARGIN < h && dark_px(p)) begin
			n = 0;
			for (int dc = 0; dc < WIN; dc++) begin
				s = (rd_slot + WIN - MARGIN + dc) % WIN;
				for (int rr = int'(r) - MARGIN; rr <= int'(r) + MARGIN; rr++)
					if (dark_px(col_mem[mem_addr(s, rr)]))
						n++;
			end
			if (n < SPECK_LIMIT) begin
				p = WHITE;
				col_mem[addr] = p;
				res.removed = 1'b1;
			end
		end
		res.red = p[3*CH_W-1:2*CH_W];
		res.green = p[2*CH_W-1:CH_W];
		res.blue = p[CH_W-1:0];
		res.column = COL_W'(c);
		res.row = ROW_W'(r);
		res.last = (c + 1 >= w) && (r + 1 >= h);
		due_pixels.push_back(res);
		rd_row++;
		if (rd_row >= h) begin
			rd_row = 0;
			rd_slot = (rd_slot + 1) % WIN;
			rd_col++;
			if (rd_col >= w)
				rd_col = 0;
		end
		if (backlog > 0)
			backlog--;
	endtask

	task automatic despeckle_step(stream_item_t it);
		int unsigned w, h;
		w = eff_cols();
		h = eff_rows();
		if (it.cmd == CMD_DRAIN) begin
			// A drain only counts at the start of a frame with pixels still pending.
			if (backlog > 0 && wr_col == 0 && wr_row == 0)
				decide_pixel();
		end else begin
			col_mem[mem_addr(wr_slot, wr_row)] = it.pix;
			wr_row++;
			if (wr_row >= h) begin
				wr_row = 0;
				wr_slot = (wr_slot + 1) % WIN;
				wr_col++;
				if (wr_col >= w)
					wr_col = 0;
			end
			if (backlog < (1 << PEND_W) - 1)
				backlog++;
			if (backlog > 2 * h + 2)
				decide_pixel();
		end
	endtask

	task automatic flag_error(string msg);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("%s", msg);
	endtask

	// Input side: the presented transaction holds until accepted, then feeds the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_PIXEL;
			red_in <= '0;
			green_in <= '0;
			blue_in <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				despeckle_step(shown_item);
				if (shown_item.cmd == CMD_DRAIN)
					drains_sent++;
				else
					pixels_sent++;
			end
			if (stream_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				shown_item = stream_items.pop_front();
				in_valid <= 1'b1;
				command <= shown_item.cmd;
				red_in <= shown_item.pix[3*CH_W-1:2*CH_W];
				green_in <= shown_item.pix[2*CH_W-1:CH_W];
				blue_in <= shown_item.pix[CH_W-1:0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side stall: random idling, plus one long hold-off that backs up the block.
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		finished_pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_pixels.size() == 0) begin
				flag_error($sformatf("unexpected pixel col %0d row %0d", out_column, out_row));
			end else begin
				want = due_pixels.pop_front();
				if (was_removed === 1'b1)
					removed_seen++;
				if ({red_out, green_out, blue_out, out_column, out_row, was_removed,
					frame_end} !== {want.red, want.green, want.blue, want.column, want.row,
					want.removed, want.last})
					flag_error($sformatf({"mismatch on result %0d: expected rgb %02x %02x %02x",
						" col %0d row %0d removed %0b end %0b, got rgb %02x %02x %02x",
						" col %0d row %0d removed %0b end %0b"}, results_seen,
						want.red, want.green, want.blue, want.column, want.row,
						want.removed, want.last, red_out, green_out, blue_out,
						out_column, out_row, was_removed, frame_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("** despeckle_dark_pixel_5x5_unit: FAILED **");
		$finish;
	end

	task automatic set_reg(cfg_reg_t idx, int unsigned value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_q = CH_W'(value);
			REG_WIDTH:     width_q = WIDTH_W'(value);
			REG_HEIGHT:    height_q = HEIGHT_W'(value);
			default: ;
		endcase
	endtask

	// Waits until the stream is empty, then drains whatever the frame left pending.
	task automatic finish_phase();
		bit done;
		done = 1'b0;
		while (!done) begin
			while (stream_items.size() != 0 || in_valid || due_pixels.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
			if (backlog == 0)
				done = 1'b1;
			else
				repeat (backlog) stream_items.push_back(make_item(CMD_DRAIN, '0));
		end
	endtask

	function automatic pixel_t random_pixel(int unsigned pct);
		logic [CH_W-1:0] ch [3];
		int unsigned     hi;
		if (thr_q == '1 || $urandom_range(99) < pct) begin
			for (int k = 0; k < 3; k++)
				ch[k] = ($urandom_range(3) == 0) ? thr_q : CH_W'($urandom_range(thr_q));
		end else begin
			for (int k = 0; k < 3; k++)
				ch[k] = CH_W'($urandom);
			hi = $urandom_range(2);
			ch[hi] = ($urandom_range(3) == 0) ? CH_W'(thr_q + 1) :
				CH_W'($urandom_range(255, int'(thr_q) + 1));
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	task automatic queue_frame(int unsigned pct);
		int total;
		total = eff_cols() * eff_rows();
		for (int k = 0; k < total; k++) begin
			// A drain inside a frame must be ignored by the block.
			if (k != 0 && $urandom_range(49) == 0)
				stream_items.push_back(make_item(CMD_DRAIN, '0));
			stream_items.push_back(make_item(CMD_PIXEL, random_pixel(pct)));
			pixels_queued++;
		end
	endtask

	task automatic run_phase(int unsigned thr, int unsigned wv, int unsigned hv,
		int unsigned frames, int unsigned pct);
		set_reg(REG_THRESHOLD, thr);
		set_reg(REG_WIDTH, wv);
		set_reg(REG_HEIGHT, hv);
		for (int f = 0; f < frames; f++) begin
			queue_frame(pct);
			// Some frames follow directly, others after a partial drain at the boundary.
			if (f + 1 < frames && $urandom_range(2) == 0)
				repeat ($urandom_range(1, 4)) stream_items.push_back(make_item(CMD_DRAIN, '0));
		end
		phases++;
		finish_phase();
	endtask

	function automatic int unsigned pick_dim();
		return ($urandom_range(4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
	endfunction

	initial begin
		pixel_t      p;
		int unsigned thr;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One 5x5 frame at the reset threshold: a lone speck at the center with three dark
		// neighbours, pixels exactly at the threshold and single channels just above it.
		set_reg(REG_WIDTH, 5);
		set_reg(REG_HEIGHT, 5);
		stream_items.push_back(make_item(CMD_DRAIN, '0));
		for (int k = 0; k < 25; k++) begin
			case (k)
				6:             p = {8'd127, 8'd127, 8'd127};
				10:            p = {8'd127, 8'd0, 8'd0};
				12:            p = '0;
				18:            p = {8'd0, 8'd127, 8'd5};
				7:             p = {8'd128, 8'd0, 8'd0};
				11:            p = {8'd0, 8'd128, 8'd0};
				13:            p = {8'd0, 8'd0, 8'd128};
				0, 4, 20, 24:  p = WHITE;
				default:       p = {CH_W'($urandom_range(255, 128)), CH_W'($urandom),
					CH_W'($urandom)};
			endcase
			if (k == 3)
				stream_items.push_back(make_item(CMD_DRAIN, '0));
			stream_items.push_back(make_item(CMD_PIXEL, p));
		end
		phases++;
		finish_phase();

		// Zero geometry clamps to a single pixel; then the threshold extremes.
		run_phase(0, 0, 0, 4, 50);
		run_phase(255, 7, 6, 1, 50);

		steady = 1'b1;
		run_phase($urandom_range(40, 200), 12, 10, 3, 20);
		steady = 1'b0;

		// The receiver holds off long enough to back up the input.
		hold_request = 1'b1;
		run_phase($urandom_range(255), 9, 7, 1, 30);

		while (pixels_queued < PIXEL_TARGET) begin
			case ($urandom_range(5))
				0:       thr = 0;
				1:       thr = 255;
				default: thr = $urandom_range(255);
			endcase
			run_phase(thr, pick_dim(), pick_dim(), $urandom_range(1, 3),
				($urandom_range(2) == 0) ? 45 : $urandom_range(5, 20));
		end

		if (due_pixels.size() != 0)
			flag_error($sformatf("%0d results never arrived", due_pixels.size()));
		$display("Ran %0d phases: %0d pixels and %0d drain transactions in, %0d pixels out,",
			phases, pixels_sent, drains_sent, results_seen);
		$display("%0d specks removed; frames up to 12 columns and 12 rows, thresholds 0 to 255.",
			removed_seen);
		if (errors == 0)
			$display("** despeckle_dark_pixel_5x5_unit: PASSED **");
		else
			$display("** despeckle_dark_pixel_5x5_unit: FAILED **");
		$finish;
	end

endmodule
